@@ rtl/core/h264sps_pkg.sv @@
// ----------------------------------------------------------------------------
// h264sps_pkg
// Shared types, codes and lookup functions of the SPS header parser.
// ----------------------------------------------------------------------------
package h264sps_pkg;

	localparam int STEP_W = 5;
	localparam int CNT_W  = 6;
	localparam int VAL_W  = 32;
	localparam int ID_W   = 5;
	localparam int ST_W   = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [VAL_W-1:0]  val_t;
	typedef logic [ID_W-1:0]   id_t;
	typedef logic [ST_W-1:0]   code_t;

	// Parse steps that steer the syntax order.
	localparam step_t STEP_HEADER     = 5'd0;
	localparam step_t STEP_PROFILE    = 5'd1;
	localparam step_t STEP_SPS_ID     = 5'd7;
	localparam step_t STEP_POC_TYPE   = 5'd9;
	localparam step_t STEP_POC_LSB    = 5'd10;
	localparam step_t STEP_POC_ZERO   = 5'd11;
	localparam step_t STEP_POC_CYCLE  = 5'd14;
	localparam step_t STEP_POC_OFFSET = 5'd15;
	localparam step_t STEP_REF_FRAMES = 5'd16;
	localparam step_t STEP_FRAME_MBS  = 5'd20;
	localparam step_t STEP_MBAFF      = 5'd21;
	localparam step_t STEP_DIRECT     = 5'd22;
	localparam step_t STEP_CROP_FLAG  = 5'd23;
	localparam step_t STEP_CROP_LEFT  = 5'd24;
	localparam step_t STEP_VUI        = 5'd28;

	localparam val_t HIGH_PROFILE_MIN = 32'd100;

	// Final status codes.
	localparam code_t ST_OK        = 3'd0;
	localparam code_t ST_TOO_SHORT = 3'd1;
	localparam code_t ST_HIGH      = 3'd2;
	localparam code_t ST_OVERRUN   = 3'd3;
	localparam code_t ST_LONG_CODE = 3'd4;

	localparam logic KIND_ELEM   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_BIT,
		S_TAIL,
		S_STATUS
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} src_cmd_t;

	typedef struct packed {
		logic take;
		logic enter_first;
		logic clear;
	} fld_cmd_t;

	typedef struct packed {
		logic  elem;
		id_t   id;
		val_t  value;
		logic  fin;
		code_t code;
		logic  high;
		logic  at_header;
	} fld_res_t;

	// Width of a u(n) field at a step; zero marks an Exp-Golomb step.
	function automatic cnt_t fixed_width(input step_t s);
		cnt_t w;
		case (s) inside
			5'd1, 5'd6:                                  w = 6'd8;
			5'd5:                                        w = 6'd5;
			5'd2, 5'd3, 5'd4, 5'd11, 5'd17, [5'd20:5'd23],
			5'd28:                                       w = 6'd1;
			default:                                     w = 6'd0;
		endcase
		return w;
	endfunction

	// Element number of a step; the valid bit is low for skipped fields.
	function automatic logic [ID_W:0] elem_of(input step_t s);
		logic [ID_W:0] r;
		case (s) inside
			[5'd1:5'd4]:   r = {1'b1, ID_W'(s - 5'd1)};
			[5'd6:5'd10]:  r = {1'b1, ID_W'(s - 5'd2)};
			[5'd16:5'd28]: r = {1'b1, ID_W'(s - 5'd7)};
			default:       r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/h264_sps_header_parser.sv @@
// ----------------------------------------------------------------------------
// h264_sps_header_parser
// Parses the RBSP bytes of one H.264 SPS unit one bit per cycle, unless the
// output stalls, and reports unskipped elements, then a final status per unit.
// ----------------------------------------------------------------------------
// A result is registered on the output when its last bit is taken.
// Each data byte is accepted in idle, shifted out bit by bit MSB first and
// closed by an end-of-byte state; no new byte is taken before that. The single
// bit-serial decode step sets this pace; a stalled output holds the bit.
// A second result from the same bit is held as a pending status and follows.
// Reset clears the parse state and the output valid flag; no clearing pass.
module h264_sps_header_parser #(
	parameter int MAX_CODE_ZEROS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [4:0]  element_id,
	output logic [31:0] element_value,
	output logic [2:0]  status,
	output logic        last_result
);

	h264sps_pkg::state_t   state_q, state_n;
	h264sps_pkg::src_cmd_t src_cmd;
	h264sps_pkg::fld_cmd_t fld_cmd;
	h264sps_pkg::fld_res_t res;

	logic bit_val, bit_last, unit_last;
	logic finished_q, fin_set;
	logic slot_free, emit;
	logic pend_ld;
	h264sps_pkg::code_t pend_q;

	logic              e_kind, e_last;
	h264sps_pkg::id_t  e_id;
	h264sps_pkg::val_t e_val;
	h264sps_pkg::code_t e_st;

	logic               out_valid_q, kind_q, last_q;
	h264sps_pkg::id_t   id_q;
	h264sps_pkg::val_t  val_q;
	h264sps_pkg::code_t st_q;

	h264sps_bitsrc u_bitsrc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (src_cmd),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.bit_val   (bit_val),
		.bit_last  (bit_last),
		.unit_last (unit_last)
	);

	h264sps_fields #(
		.MAX_CODE_ZEROS (MAX_CODE_ZEROS)
	) u_fields (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (fld_cmd),
		.bit_val (bit_val),
		.res     (res)
	);

	assign in_stall  = (state_q != h264sps_pkg::S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= h264sps_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		src_cmd = '0;
		fld_cmd = '0;
		emit    = 1'b0;
		e_kind  = h264sps_pkg::KIND_STATUS;
		e_id    = '0;
		e_val   = '0;
		e_st    = h264sps_pkg::ST_OK;
		e_last  = 1'b1;
		fin_set = 1'b0;
		pend_ld = 1'b0;
		case (state_q)
			h264sps_pkg::S_IDLE: begin
				if (in_valid) begin
					src_cmd.load = 1'b1;
					if (finished_q) begin
						fld_cmd.clear = last_byte;
					end else if (res.at_header) begin
						state_n = h264sps_pkg::S_HDR;
					end else begin
						state_n = h264sps_pkg::S_BIT;
					end
				end
			end
			h264sps_pkg::S_HDR: begin
				if (!unit_last) begin
					fld_cmd.enter_first = 1'b1;
					state_n             = h264sps_pkg::S_IDLE;
				end else if (slot_free) begin
					emit          = 1'b1;
					e_st          = h264sps_pkg::ST_TOO_SHORT;
					fld_cmd.clear = 1'b1;
					state_n       = h264sps_pkg::S_IDLE;
				end
			end
			h264sps_pkg::S_BIT: begin
				if (!(res.elem || res.fin) || slot_free) begin
					fld_cmd.take = 1'b1;
					if (res.elem) begin
						emit   = 1'b1;
						e_kind = h264sps_pkg::KIND_ELEM;
						e_id   = res.id;
						e_val  = res.value;
						e_last = 1'b0;
					end else if (res.fin) begin
						emit = 1'b1;
						e_st = res.code;
					end
					if (res.fin && res.elem) begin
						// Element and final status from one bit: status goes next.
						pend_ld = 1'b1;
						state_n = h264sps_pkg::S_STATUS;
					end else if (res.fin) begin
						fld_cmd.clear = unit_last;
						fin_set       = !unit_last;
						state_n       = h264sps_pkg::S_IDLE;
					end else if (bit_last) begin
						state_n = h264sps_pkg::S_TAIL;
					end else begin
						src_cmd.shift = 1'b1;
					end
				end
			end
			h264sps_pkg::S_TAIL: begin
				if (!unit_last) begin
					state_n = h264sps_pkg::S_IDLE;
				end else if (slot_free) begin
					emit          = 1'b1;
					e_st          = res.high ? h264sps_pkg::ST_HIGH : h264sps_pkg::ST_OVERRUN;
					fld_cmd.clear = 1'b1;
					state_n       = h264sps_pkg::S_IDLE;
				end
			end
			h264sps_pkg::S_STATUS: begin
				if (slot_free) begin
					emit          = 1'b1;
					e_st          = pend_q;
					fld_cmd.clear = unit_last;
					fin_set       = !unit_last;
					state_n       = h264sps_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = h264sps_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b0;
		end else if (fld_cmd.clear) begin
			finished_q <= 1'b0;
		end else if (fin_set) begin
			finished_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_ld) begin
			pend_q <= res.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			id_q   <= e_id;
			val_q  <= e_val;
			st_q   <= e_st;
			last_q <= e_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign element_id    = id_q;
	assign element_value = val_q;
	assign status        = st_q;
	assign last_result   = last_q;

	// A byte taken while parsing must hold off the next one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !finished_q) |=> in_stall)
		else $error("input taken again before the byte was parsed");

	// Trailing bytes are only ever dropped from the idle state.
	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (state_q == h264sps_pkg::S_IDLE))
		else $error("parser busy while waiting for end of unit");

	// Element transactions carry no status and never close the unit.
	a_elem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == h264sps_pkg::KIND_ELEM) |->
		(status == h264sps_pkg::ST_OK && !last_result))
		else $error("element transaction with status fields set");

	// A status transaction always closes the unit.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == h264sps_pkg::KIND_STATUS) |-> last_result)
		else $error("status transaction without last marker");

	// A pending status is emitted without consuming another bit.
	a_status_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == h264sps_pkg::S_STATUS) |-> !fld_cmd.take)
		else $error("bit consumed while a status is pending");

endmodule

@@ rtl/core/h264sps_bitsrc.sv @@
// ----------------------------------------------------------------------------
// h264sps_bitsrc
// Byte shift register that presents one bit per cycle while shifted, MSB first.
// ----------------------------------------------------------------------------
module h264sps_bitsrc (
	input  logic                clk,
	input  logic                arst_n,
	input  h264sps_pkg::src_cmd_t cmd,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                bit_val,
	output logic                bit_last,
	output logic                unit_last
);

	logic [7:0] sh_q;
	logic [2:0] cnt_q;
	logic       last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= '0;
			last_q <= last_byte;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q <= data_byte;
		end else if (cmd.shift) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

	assign bit_val   = sh_q[7];
	assign bit_last  = (cnt_q == 3'd7);
	assign unit_last = last_q;

endmodule

@@ rtl/core/h264sps_fields.sv @@
// ----------------------------------------------------------------------------
// h264sps_fields
// Bit-serial field decoder: u(n) and ue(v) accumulation and SPS step order.
// ----------------------------------------------------------------------------
module h264sps_fields #(
	parameter int MAX_CODE_ZEROS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  h264sps_pkg::fld_cmd_t cmd,
	input  logic                  bit_val,
	output h264sps_pkg::fld_res_t res
);

	localparam h264sps_pkg::cnt_t MAX_Z = h264sps_pkg::cnt_t'(MAX_CODE_ZEROS);

	h264sps_pkg::step_t step_q, step_n;
	h264sps_pkg::cnt_t  zc_q, zc_n, br_q, br_n, fw;
	h264sps_pkg::val_t  acc_q, acc_n, skip_q, skip_n, v, acc_sh, skip_dec;
	logic               hp_q, hp_n, done;
	logic [h264sps_pkg::ID_W:0] eid;

	always_comb begin
		step_n   = step_q;
		zc_n     = zc_q;
		br_n     = br_q;
		acc_n    = acc_q;
		skip_n   = skip_q;
		hp_n     = hp_q;
		done     = 1'b0;
		v        = '0;
		res      = '0;
		fw       = h264sps_pkg::fixed_width(step_q);
		eid      = h264sps_pkg::elem_of(step_q);
		acc_sh   = {acc_q[h264sps_pkg::VAL_W-2:0], bit_val};
		skip_dec = skip_q - 32'd1;

		if (step_q == h264sps_pkg::STEP_HEADER || step_q > h264sps_pkg::STEP_VUI) begin
			res.fin  = 1'b1;
			res.code = h264sps_pkg::ST_OVERRUN;
		end else if (fw != '0) begin
			acc_n = acc_sh;
			br_n  = (br_q != '0) ? br_q - 6'd1 : '0;
			if (br_n == '0) begin
				done = 1'b1;
				v    = acc_sh;
			end
		end else if (br_q == '0) begin
			if (!bit_val) begin
				zc_n = zc_q + 6'd1;
				if (zc_n > MAX_Z) begin
					res.fin  = 1'b1;
					res.code = h264sps_pkg::ST_LONG_CODE;
				end
			end else begin
				acc_n = 32'd1;
				if (zc_q != '0) begin
					br_n = zc_q;
				end else begin
					done = 1'b1;
				end
			end
		end else begin
			acc_n = acc_sh;
			br_n  = br_q - 6'd1;
			if (br_n == '0) begin
				done = 1'b1;
				v    = acc_sh - 32'd1;
			end
		end

		if (done) begin
			res.elem  = eid[h264sps_pkg::ID_W];
			res.id    = eid[h264sps_pkg::ID_W-1:0];
			res.value = v;
			step_n    = step_q + 5'd1;
			case (step_q)
				h264sps_pkg::STEP_PROFILE: begin
					hp_n = (v >= h264sps_pkg::HIGH_PROFILE_MIN);
				end
				h264sps_pkg::STEP_SPS_ID: begin
					if (hp_q) begin
						res.fin  = 1'b1;
						res.code = h264sps_pkg::ST_HIGH;
					end
				end
				h264sps_pkg::STEP_POC_TYPE: begin
					step_n = (v == 32'd0) ? h264sps_pkg::STEP_POC_LSB :
						(v == 32'd1) ? h264sps_pkg::STEP_POC_ZERO :
						h264sps_pkg::STEP_REF_FRAMES;
				end
				h264sps_pkg::STEP_POC_LSB: begin
					step_n = h264sps_pkg::STEP_REF_FRAMES;
				end
				h264sps_pkg::STEP_POC_CYCLE: begin
					skip_n = v;
					step_n = (v == 32'd0) ? h264sps_pkg::STEP_REF_FRAMES :
						h264sps_pkg::STEP_POC_OFFSET;
				end
				h264sps_pkg::STEP_POC_OFFSET: begin
					skip_n = skip_dec;
					step_n = (skip_dec == 32'd0) ? h264sps_pkg::STEP_REF_FRAMES :
						h264sps_pkg::STEP_POC_OFFSET;
				end
				h264sps_pkg::STEP_FRAME_MBS: begin
					step_n = (v != 32'd0) ? h264sps_pkg::STEP_DIRECT :
						h264sps_pkg::STEP_MBAFF;
				end
				h264sps_pkg::STEP_CROP_FLAG: begin
					step_n = (v != 32'd0) ? h264sps_pkg::STEP_CROP_LEFT :
						h264sps_pkg::STEP_VUI;
				end
				h264sps_pkg::STEP_VUI: begin
					res.fin  = 1'b1;
					res.code = h264sps_pkg::ST_OK;
				end
				default: begin
				end
			endcase
			if (!res.fin) begin
				zc_n  = '0;
				acc_n = '0;
				br_n  = h264sps_pkg::fixed_width(step_n);
			end else begin
				step_n = step_q;
			end
		end

		res.high      = hp_q;
		res.at_header = (step_q == h264sps_pkg::STEP_HEADER);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= h264sps_pkg::STEP_HEADER;
			zc_q   <= '0;
			br_q   <= '0;
			acc_q  <= '0;
			skip_q <= '0;
			hp_q   <= 1'b0;
		end else if (cmd.clear) begin
			step_q <= h264sps_pkg::STEP_HEADER;
			zc_q   <= '0;
			br_q   <= '0;
			acc_q  <= '0;
			skip_q <= '0;
			hp_q   <= 1'b0;
		end else if (cmd.enter_first) begin
			step_q <= h264sps_pkg::STEP_PROFILE;
			zc_q   <= '0;
			br_q   <= h264sps_pkg::fixed_width(h264sps_pkg::STEP_PROFILE);
			acc_q  <= '0;
		end else if (cmd.take) begin
			step_q <= step_n;
			zc_q   <= zc_n;
			br_q   <= br_n;
			acc_q  <= acc_n;
			skip_q <= skip_n;
			hp_q   <= hp_n;
		end
	end

endmodule
